// File: hdl/mdl_pkg.sv
// shared constants and types for the magnetic disturbance level block
`timescale 1ns / 1ps

package mdl_pkg;

  // sample format
  localparam int SAMPLE_W = 15;
  localparam int AXES = 3;
  // samples are in 1/16 microtesla
  localparam int SAMPLE_SCALE = 16;

  // default window geometry
  localparam int WINDOW_LEN_DEF = 15;
  localparam int RECENT_LEN_DEF = 3;

  // beat widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;
  localparam int LEVEL_W = 4;

  // result codes
  localparam logic [LEVEL_W-1:0] LEVEL_FILLING = 4'h0;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'h9;
  localparam logic [LEVEL_W-1:0] LEVEL_DISABLED = 4'hF;

  // grade thresholds in microtesla
  localparam int NUM_GRADES = 8;
  localparam int GRADE_LIMITS_UT [NUM_GRADES] = '{5, 10, 15, 20, 30, 40, 60, 100};

  // what a beat in flight reports
  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_FILLING  = 2'd1,
    MODE_GRADE    = 2'd2
  } mode_t;

  // control handed from the window stage to the grading stages
  typedef struct packed {
    logic  valid;
    mode_t mode;
  } win_ctrl_t;

endpackage

// File: hdl/mdl_window.sv
// sample window: shift line of samples with running window and recent sums
`timescale 1ns / 1ps

module mdl_window #(
  parameter int WINDOW_LEN = mdl_pkg::WINDOW_LEN_DEF,
  parameter int RECENT_LEN = mdl_pkg::RECENT_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   enable,
  input  logic signed [mdl_pkg::SAMPLE_W-1:0]    sample [mdl_pkg::AXES],
  output mdl_pkg::win_ctrl_t                     ctrl,
  input  logic                                   out_ready,
  output logic signed [mdl_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0] win_sum [mdl_pkg::AXES],
  output logic signed [mdl_pkg::SAMPLE_W+$clog2(RECENT_LEN)-1:0] rec_sum [mdl_pkg::AXES]
);

  localparam int SW = mdl_pkg::SAMPLE_W;
  localparam int SUM_W = SW + $clog2(WINDOW_LEN);
  localparam int RSUM_W = SW + $clog2(RECENT_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic signed [SW-1:0]     taps [WINDOW_LEN][mdl_pkg::AXES];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     full;
  logic                     rec_full;
  logic                     load;
  logic signed [SUM_W-1:0]  win_sum_next [mdl_pkg::AXES];
  logic signed [RSUM_W-1:0] rec_sum_next [mdl_pkg::AXES];
  mdl_pkg::mode_t           mode_next;

  // stage moves when its result is taken or it is empty
  assign in_ready = !ctrl.valid || out_ready;
  assign load = in_valid && in_ready;

  // running sums drop the sample that leaves each window
  always_comb begin
    full = (count == CNT_W'(WINDOW_LEN));
    rec_full = (count >= CNT_W'(RECENT_LEN));
    count_next = full ? count : count + CNT_W'(1);
    for (int a = 0; a < mdl_pkg::AXES; a++) begin
      win_sum_next[a] = win_sum[a] + SUM_W'(sample[a])
                        - (full ? SUM_W'(taps[WINDOW_LEN-1][a]) : SUM_W'(0));
      rec_sum_next[a] = rec_sum[a] + RSUM_W'(sample[a])
                        - (rec_full ? RSUM_W'(taps[RECENT_LEN-1][a]) : RSUM_W'(0));
    end
    if (!enable) begin
      mode_next = mdl_pkg::MODE_DISABLED;
    end else if (count_next == CNT_W'(WINDOW_LEN)) begin
      mode_next = mdl_pkg::MODE_GRADE;
    end else begin
      mode_next = mdl_pkg::MODE_FILLING;
    end
  end

  // control, fill count and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
      ctrl.mode <= mdl_pkg::MODE_FILLING;
      count <= '0;
      for (int a = 0; a < mdl_pkg::AXES; a++) begin
        win_sum[a] <= '0;
        rec_sum[a] <= '0;
      end
    end else begin
      if (in_ready) begin
        ctrl.valid <= in_valid;
      end
      if (load) begin
        ctrl.mode <= mode_next;
      end
      if (load && enable) begin
        count <= count_next;
        for (int a = 0; a < mdl_pkg::AXES; a++) begin
          win_sum[a] <= win_sum_next[a];
          rec_sum[a] <= rec_sum_next[a];
        end
      end
    end
  end

  // sample shift line, newest at tap 0
  always_ff @(posedge clk) begin
    if (load && enable) begin
      for (int a = 0; a < mdl_pkg::AXES; a++) begin
        taps[0][a] <= sample[a];
        for (int i = 1; i < WINDOW_LEN; i++) begin
          taps[i][a] <= taps[i-1][a];
        end
      end
    end
  end

  // fill count never passes the window length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_LEN))
    else $error("window fill count overran");

  // a graded beat only leaves once the window is full
  a_grade_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid && ctrl.mode == mdl_pkg::MODE_GRADE |-> full)
    else $error("grade issued before window full");

  // a disabled beat leaves the window untouched
  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    load && !enable |=> $stable(count) && $stable(win_sum[0]))
    else $error("disabled beat changed window state");

endmodule

// File: hdl/magnetic_disturbance_level.sv
// magnetic disturbance level: short against long moving average change grader
`timescale 1ns / 1ps

// One three-axis sample beat is accepted every clock while the output is not
// stalled, and each beat yields one motion_level beat. The four register stages,
// the first loaded at the accepting edge, are: window update (shift line and
// running sums), per-axis difference |R*Sw - W*Sr|, three-axis total, and
// threshold grading. Level 0 is reported while the first WINDOW_LEN-1 samples
// arrive, 1 to 9 grade the disturbance, and 15 is reported while sensor_enable
// is low, in which case the sample is dropped. There is no clearing pass after
// reset.
module magnetic_disturbance_level #(
  parameter int WINDOW_LEN = mdl_pkg::WINDOW_LEN_DEF,
  parameter int RECENT_LEN = mdl_pkg::RECENT_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sensor_enable_we,
  input  logic                            sensor_enable_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample_x [14:0], sample_y [29:15], sample_z [44:30], zero [47:45]
  input  logic [mdl_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // motion_level [3:0], zero [7:4]
  output logic [mdl_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int SW = mdl_pkg::SAMPLE_W;
  localparam int AX = mdl_pkg::AXES;
  localparam int SUM_W = SW + $clog2(WINDOW_LEN);
  localparam int RSUM_W = SW + $clog2(RECENT_LEN);
  localparam int D_W = SW + $clog2(RECENT_LEN) + $clog2(WINDOW_LEN) + 2;
  localparam int TOT_W = D_W + 2;
  localparam int UNIT = mdl_pkg::SAMPLE_SCALE * WINDOW_LEN * RECENT_LEN;
  localparam logic signed [D_W-1:0] R_C = D_W'(RECENT_LEN);
  localparam logic signed [D_W-1:0] W_C = D_W'(WINDOW_LEN);

  logic                        sensor_enable;
  logic signed [SW-1:0]        sample [AX];
  mdl_pkg::win_ctrl_t          win_ctrl;
  logic signed [SUM_W-1:0]     win_sum [AX];
  logic signed [RSUM_W-1:0]    rec_sum [AX];
  logic                        s2_valid;
  logic                        s2_ready;
  mdl_pkg::mode_t              s2_mode;
  logic [D_W-1:0]              s2_abs [AX];
  logic [D_W-1:0]              abs_next [AX];
  logic signed [D_W-1:0]       diff [AX];
  logic                        s3_valid;
  logic                        s3_ready;
  mdl_pkg::mode_t              s3_mode;
  logic [TOT_W-1:0]            s3_total;
  logic [TOT_W-1:0]            total_next;
  logic                        out_ready;
  logic [mdl_pkg::LEVEL_W-1:0] grade;
  logic [mdl_pkg::LEVEL_W-1:0] level_next;
  logic [mdl_pkg::LEVEL_W-1:0] level;

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable <= 1'b1;
    end else if (sensor_enable_we) begin
      sensor_enable <= sensor_enable_wdata;
    end
  end

  // unpack the sample beat
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      sample[a] = s_tdata[a*SW +: SW];
    end
  end

  mdl_window #(
    .WINDOW_LEN(WINDOW_LEN),
    .RECENT_LEN(RECENT_LEN)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .enable(sensor_enable),
    .sample(sample),
    .ctrl(win_ctrl),
    .out_ready(s2_ready),
    .win_sum(win_sum),
    .rec_sum(rec_sum)
  );

  // ready chain, each stage moves when empty or drained
  assign out_ready = !m_tvalid || m_tready;
  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;

  // per-axis scaled difference of the two means
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      diff[a] = D_W'(win_sum[a]) * R_C - D_W'(rec_sum[a]) * W_C;
      abs_next[a] = diff[a][D_W-1] ? D_W'(-diff[a]) : D_W'(diff[a]);
    end
  end

  // three-axis total
  always_comb begin
    total_next = '0;
    for (int a = 0; a < AX; a++) begin
      total_next = total_next + TOT_W'(s2_abs[a]);
    end
  end

  // lowest threshold above the total picks the grade
  always_comb begin
    grade = mdl_pkg::LEVEL_MAX;
    for (int i = mdl_pkg::NUM_GRADES - 1; i >= 0; i--) begin
      if (s3_total < TOT_W'(UNIT * mdl_pkg::GRADE_LIMITS_UT[i])) begin
        grade = mdl_pkg::LEVEL_W'(i + 1);
      end
    end
  end

  // result code by beat kind
  always_comb begin
    unique case (s3_mode)
      mdl_pkg::MODE_DISABLED: level_next = mdl_pkg::LEVEL_DISABLED;
      mdl_pkg::MODE_FILLING:  level_next = mdl_pkg::LEVEL_FILLING;
      mdl_pkg::MODE_GRADE:    level_next = grade;
      default:                level_next = mdl_pkg::LEVEL_FILLING;
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= win_ctrl.valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        m_tvalid <= s3_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s2_ready && win_ctrl.valid) begin
      s2_mode <= win_ctrl.mode;
      for (int a = 0; a < AX; a++) begin
        s2_abs[a] <= abs_next[a];
      end
    end
    if (s3_ready && s2_valid) begin
      s3_mode <= s2_mode;
      s3_total <= total_next;
    end
    if (out_ready && s3_valid) begin
      level <= level_next;
    end
  end

  assign m_tdata = {{(mdl_pkg::M_TDATA_W - mdl_pkg::LEVEL_W){1'b0}}, level};

  // only grades, filling or disabled codes leave the block
  a_level_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (level <= mdl_pkg::LEVEL_MAX || level == mdl_pkg::LEVEL_DISABLED))
    else $error("illegal motion level");

  // a stalled result is kept
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(level))
    else $error("stalled result lost");

  // a free window stage always takes a beat
  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !win_ctrl.valid |-> s_tready)
    else $error("input stalled with empty window stage");

  // a grade beat never carries the disabled or the filling code
  a_grade_code: assert property (@(posedge clk) disable iff (rst)
    s3_valid && out_ready && s3_mode == mdl_pkg::MODE_GRADE |=>
      level != mdl_pkg::LEVEL_DISABLED && level != mdl_pkg::LEVEL_FILLING)
    else $error("grade beat produced a non-grade code");

endmodule

// File: verif/mdl_level_checker.sv
// beat monitor and window predictor that checks every motion_level result
`timescale 1ns / 1ps

module mdl_level_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // sample_x [14:0], sample_y [29:15], sample_z [44:30], zero [47:45]
  input  logic [mdl_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // motion_level [3:0], zero [7:4]
  input  logic [mdl_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending,
  output int                            levels_checked,
  output logic [15:0]                   levels_seen
);

  localparam int WIN = mdl_pkg::WINDOW_LEN_DEF;
  localparam int REC = mdl_pkg::RECENT_LEN_DEF;
  localparam int AXES = mdl_pkg::AXES;
  localparam int SW = mdl_pkg::SAMPLE_W;
  // one microtesla of summed mean difference in the scaled integer domain
  localparam longint UT_STEP = mdl_pkg::SAMPLE_SCALE * WIN * REC;
  localparam int NUM_BOUNDS = 8;
  localparam int BOUND_UT [NUM_BOUNDS] = '{5, 10, 15, 20, 30, 40, 60, 100};

  // shadow copy of the block state
  logic   sensor_on;
  int     window_ring [WIN][AXES];
  int     ring_slot;
  bit     ring_full;
  longint axis_sums [AXES];

  logic [mdl_pkg::LEVEL_W-1:0] expected_levels [$];
  logic [mdl_pkg::LEVEL_W-1:0] got_level;
  logic [mdl_pkg::LEVEL_W-1:0] want_level;

  // store one sample in the window and return the level it produces
  function automatic logic [mdl_pkg::LEVEL_W-1:0] advance_window(
    input logic [mdl_pkg::S_TDATA_W-1:0] beat
  );
    logic signed [SW-1:0] field;
    longint recent;
    longint diff;
    longint total;
    int pos;
    logic [mdl_pkg::LEVEL_W-1:0] lvl;
    for (int a = 0; a < AXES; a++) begin
      field = beat[a*SW +: SW];
      if (ring_full) axis_sums[a] -= window_ring[ring_slot][a];
      window_ring[ring_slot][a] = int'(field);
      axis_sums[a] += int'(field);
    end
    ring_slot++;
    if (ring_slot == WIN) begin
      ring_slot = 0;
      ring_full = 1'b1;
    end
    if (!ring_full) return mdl_pkg::LEVEL_FILLING;

    // sum over axes of |R*Sw - W*Sr|, newest samples sit just below ring_slot
    total = 0;
    for (int a = 0; a < AXES; a++) begin
      recent = 0;
      pos = ring_slot;
      for (int k = 0; k < REC; k++) begin
        pos = (pos == 0) ? WIN - 1 : pos - 1;
        recent += window_ring[pos][a];
      end
      diff = REC * axis_sums[a] - WIN * recent;
      if (diff < 0) diff = -diff;
      total += diff;
    end

    // lowest threshold that the total stays under sets the grade
    lvl = mdl_pkg::LEVEL_MAX;
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (total < UT_STEP * BOUND_UT[i]) lvl = mdl_pkg::LEVEL_W'(i + 1);
    end
    return lvl;
  endfunction

  // watch both channels and the config port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      sensor_on = 1'b1;
      ring_slot = 0;
      ring_full = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        axis_sums[a] = 0;
        for (int k = 0; k < WIN; k++) window_ring[k][a] = 0;
      end
      expected_levels.delete();
      fail_count = 0;
      levels_checked = 0;
      levels_seen = '0;
    end else begin
      if (cfg_we) sensor_on = cfg_wdata;

      if (s_tvalid && s_tready) begin
        if (sensor_on) expected_levels.push_back(advance_window(s_tdata));
        else expected_levels.push_back(mdl_pkg::LEVEL_DISABLED);
      end

      if (m_tvalid && m_tready) begin
        got_level = m_tdata[mdl_pkg::LEVEL_W-1:0];
        if (expected_levels.size() == 0) begin
          $display("%0t: motion_level beat with nothing expected, actual %0d",
                   $time, got_level);
          fail_count++;
        end else begin
          want_level = expected_levels.pop_front();
          if (got_level !== want_level) begin
            $display("%0t: motion_level mismatch, expected %0d, actual %0d",
                     $time, want_level, got_level);
            fail_count++;
          end
        end
        levels_checked++;
        if (!$isunknown(got_level)) levels_seen[got_level] = 1'b1;
      end
    end
    pending = expected_levels.size();
  end

endmodule

// File: verif/tb_top.sv
// top of the magnetic disturbance level testbench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 150000;
  localparam int RANDOM_TARGET = 1700;
  localparam int PHASE_BEATS = 300;
  localparam int DISABLED_BEATS = 20;
  localparam int IDLE_PCT = 18;
  // a few cycles beyond the four-stage pipeline
  localparam int SETTLE_CYCLES = 8;
  localparam int SAMPLE_MAX = 16383;
  localparam int SAMPLE_MIN = -16384;
  // step sizes in 1/16 microtesla, roughly bracketing each grade threshold
  localparam int STEP_BOUNDS [10] = '{0, 100, 200, 300, 400, 600, 800, 1200, 2000, 4000};

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic                          cfg_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [mdl_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [mdl_pkg::M_TDATA_W-1:0] m_tdata;

  int          fail_count;
  int          pending;
  int          levels_checked;
  logic [15:0] levels_seen;

  int   cycle_count;
  int   idle_pct = IDLE_PCT;
  logic enable_now = 1'b1;
  int   enabled_beats = 0;
  int   disabled_beats = 0;

  magnetic_disturbance_level dut (
    .clk                 (clk),
    .rst                 (rst),
    .sensor_enable_we    (cfg_we),
    .sensor_enable_wdata (cfg_wdata),
    .s_tvalid            (s_tvalid),
    .s_tready            (s_tready),
    .s_tdata             (s_tdata),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata)
  );

  mdl_level_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .levels_checked (levels_checked),
    .levels_seen    (levels_seen)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** magnetic_disturbance_level: FAILED **");
    $finish;
  end

  function automatic int clamp_sample(input int v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input int sx, input int sy, input int sz);
    logic [mdl_pkg::SAMPLE_W-1:0] fx;
    logic [mdl_pkg::SAMPLE_W-1:0] fy;
    logic [mdl_pkg::SAMPLE_W-1:0] fz;
    fx = sx[mdl_pkg::SAMPLE_W-1:0];
    fy = sy[mdl_pkg::SAMPLE_W-1:0];
    fz = sz[mdl_pkg::SAMPLE_W-1:0];
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, fz, fy, fx};
    do @(posedge clk); while (!s_tready);
    if (enable_now) enabled_beats++;
    else disabled_beats++;
  endtask

  // drain all results, let the pipeline settle, then write sensor_enable
  task automatic write_sensor_enable(input logic en);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we <= 1'b0;
    enable_now = en;
  endtask

  // a run of samples jittering around one field vector
  task automatic send_around(input int cx, input int cy, input int cz,
                             input int noise, input int count);
    repeat (count) begin
      send_sample(clamp_sample(cx + int'($urandom_range(2 * noise)) - noise),
                  clamp_sample(cy + int'($urandom_range(2 * noise)) - noise),
                  clamp_sample(cz + int'($urandom_range(2 * noise)) - noise));
    end
  endtask

  // mostly a steady field followed by a step, sometimes raw noise or rail values
  task automatic run_episode();
    int kind;
    int noise;
    int mag;
    int cls;
    int axis_mask;
    int base [3];
    int pt [3];
    kind = $urandom_range(9);
    if (kind <= 6) begin
      for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(24000)) - 12000;
      noise = $urandom_range(8);
      cls = $urandom_range(8);
      mag = $urandom_range(STEP_BOUNDS[cls + 1], STEP_BOUNDS[cls]);
      axis_mask = $urandom_range(7, 1);
      send_around(base[0], base[1], base[2], noise, $urandom_range(25, 12));
      for (int a = 0; a < 3; a++) begin
        if (axis_mask[a]) base[a] += $urandom_range(1) ? mag : -mag;
      end
      send_around(base[0], base[1], base[2], noise, $urandom_range(18, 2));
    end else if (kind == 7 || kind == 8) begin
      repeat ($urandom_range(20, 5)) send_sample($urandom, $urandom, $urandom);
    end else begin
      repeat ($urandom_range(15, 5)) begin
        for (int a = 0; a < 3; a++) begin
          case ($urandom_range(3))
            0: pt[a] = SAMPLE_MIN;
            1: pt[a] = SAMPLE_MAX;
            2: pt[a] = 0;
            default: pt[a] = -1;
          endcase
        end
        send_sample(pt[0], pt[1], pt[2]);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int random_goal;
    int phase;
    int phase_end;
    logic en;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the window with full-scale x and y samples and z at 0 or -1; the last fill beat already grades
    for (int i = 0; i < mdl_pkg::WINDOW_LEN_DEF; i++) begin
      send_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN, i[1] ? SAMPLE_MAX : SAMPLE_MIN,
                  i[2] ? -1 : 0);
    end
    // large jump on all axes, then a return to zero
    repeat (3) send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(0, 0, 0);
    // disabled samples must leave the window untouched
    write_sensor_enable(1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, -1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
    write_sensor_enable(1'b1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_sample(-1, 0, SAMPLE_MIN);

    // random phases; every third runs disabled, the second runs without idling
    random_goal = enabled_beats + RANDOM_TARGET;
    phase = 0;
    while (enabled_beats < random_goal) begin
      en = (phase % 3 != 2);
      idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      write_sensor_enable(en);
      if (!en) begin
        repeat (DISABLED_BEATS) send_sample($urandom, $urandom, $urandom);
      end else begin
        phase_end = enabled_beats + PHASE_BEATS;
        while (enabled_beats < phase_end && enabled_beats < random_goal) run_episode();
      end
      phase++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d processed and %0d disabled samples over %0d config phases",
             enabled_beats, disabled_beats, phase + 2);
    $display("%0d motion_level beats compared, levels seen (bit per level) %b",
             levels_checked, levels_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** magnetic_disturbance_level: PASSED **");
    end else begin
      $display("** magnetic_disturbance_level: FAILED **");
    end
    $finish;
  end

endmodule
